[sv/mlfd_pkg.sv]
// ----------------------------------------------------------------------------
// mlfd_pkg
// Shared types and constants for the magic/length frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfd_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_MAGIC0 = 3'd0,
    PH_MAGIC1 = 3'd1,
    PH_HEADER = 3'd2,
    PH_PATH   = 3'd3,
    PH_DATA   = 3'd4
  } mlfd_phase_t;

  // Result kinds (carried on tuser)
  localparam logic [1:0] KIND_PATH   = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIRST_MAGIC  = 2'd0;
  localparam logic [1:0] CFG_SECOND_MAGIC = 2'd1;
  localparam logic [1:0] CFG_PATH_LIMIT   = 2'd2;
  localparam logic [1:0] CFG_DATA_LIMIT   = 2'd3;

  // Configuration reset values
  localparam logic [7:0]  FIRST_MAGIC_RST  = 8'hB5;
  localparam logic [7:0]  SECOND_MAGIC_RST = 8'h0B;
  localparam logic [16:0] PATH_LIMIT_RST   = 17'd64;
  localparam logic [31:0] DATA_LIMIT_RST   = 32'd614400;

  // Header holds six bytes; index of the final one
  localparam logic [2:0] HDR_LAST_IDX = 3'd5;

  typedef struct packed {
    logic [7:0]  first_magic;
    logic [7:0]  second_magic;
    logic [16:0] path_limit;
    logic [31:0] data_limit;
  } mlfd_cfg_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic        last;
    logic [15:0] path_length;
    logic [31:0] data_length;
  } mlfd_result_t;

endpackage

`default_nettype wire

[sv/mlfd_parser.sv]
// ----------------------------------------------------------------------------
// mlfd_parser
// Frame state machine: sync search, header capture and checks, path/data
// byte counting. Produces at most one result per consumed byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfd_parser (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,       // consume in_byte this cycle
  input  wire logic [7:0]           in_byte,
  input  wire mlfd_pkg::mlfd_cfg_t  cfg,
  output mlfd_pkg::mlfd_result_t    result
);
  import mlfd_pkg::*;

  mlfd_phase_t  phase, phase_next;
  logic [2:0]   hdr_count, hdr_count_next;
  logic [39:0]  hdr, hdr_next;          // first five header bytes, byte 0 lowest
  logic [15:0]  held_path, held_path_next;
  logic [31:0]  held_data, held_data_next;
  logic [31:0]  byte_count, byte_count_next;

  // Shared decode terms
  logic [15:0] dec_path;
  logic [31:0] dec_data;
  logic        hdr_done;
  logic        reject;
  logic [31:0] cnt_inc;
  logic        path_done;
  logic        data_done;

  assign dec_path  = hdr[15:0];
  assign dec_data  = {in_byte, hdr[39:16]};
  assign hdr_done  = (hdr_count == HDR_LAST_IDX);
  assign reject    = (dec_path == 16'd0) || ({1'b0, dec_path} >= cfg.path_limit) ||
                     (dec_data > cfg.data_limit);
  assign cnt_inc   = byte_count + 32'd1;
  assign path_done = (cnt_inc == {16'd0, held_path});
  assign data_done = (cnt_inc == held_data);

  // Next state
  always_comb begin
    phase_next      = phase;
    hdr_count_next  = hdr_count;
    hdr_next        = hdr;
    held_path_next  = held_path;
    held_data_next  = held_data;
    byte_count_next = byte_count;
    case (phase)
      PH_MAGIC1: begin
        if (in_byte == cfg.second_magic) begin
          phase_next     = PH_HEADER;
          hdr_count_next = 3'd0;
        end else begin
          phase_next = PH_MAGIC0;
        end
      end
      PH_HEADER: begin
        hdr_next = {in_byte, hdr[39:8]};
        if (hdr_done) begin
          hdr_count_next = 3'd0;
          held_path_next = dec_path;
          held_data_next = dec_data;
          if (reject) begin
            phase_next = PH_MAGIC0;
          end else begin
            byte_count_next = 32'd0;
            phase_next      = PH_PATH;
          end
        end else begin
          hdr_count_next = hdr_count + 3'd1;
        end
      end
      PH_PATH: begin
        byte_count_next = cnt_inc;
        if (path_done) begin
          if (held_data == 32'd0) begin
            phase_next = PH_MAGIC0;
          end else begin
            byte_count_next = 32'd0;
            phase_next      = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        byte_count_next = cnt_inc;
        if (data_done) phase_next = PH_MAGIC0;
      end
      default: begin
        phase_next = (in_byte == cfg.first_magic) ? PH_MAGIC1 : PH_MAGIC0;
      end
    endcase
  end

  // Result for the byte being consumed
  always_comb begin
    result.valid       = 1'b0;
    result.kind        = KIND_PATH;
    result.payload     = in_byte;
    result.last        = 1'b0;
    result.path_length = held_path;
    result.data_length = held_data;
    case (phase)
      PH_HEADER: begin
        result.valid       = hdr_done && reject;
        result.kind        = KIND_REJECT;
        result.payload     = 8'd0;
        result.path_length = dec_path;
        result.data_length = dec_data;
      end
      PH_PATH: begin
        result.valid = 1'b1;
        result.kind  = KIND_PATH;
        result.last  = path_done && (held_data == 32'd0);
      end
      PH_DATA: begin
        result.valid = 1'b1;
        result.kind  = KIND_DATA;
        result.last  = data_done;
      end
      default: begin
        result.valid = 1'b0;
      end
    endcase
  end

  // State registers; header bytes need no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_MAGIC0;
      hdr_count  <= 3'd0;
      held_path  <= 16'd0;
      held_data  <= 32'd0;
      byte_count <= 32'd0;
    end else if (step) begin
      phase      <= phase_next;
      hdr_count  <= hdr_count_next;
      held_path  <= held_path_next;
      held_data  <= held_data_next;
      byte_count <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) hdr <= hdr_next;
  end

endmodule

`default_nettype wire

[sv/mlfd_out_stage.sv]
// ----------------------------------------------------------------------------
// mlfd_out_stage
// Output register holding one result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfd_out_stage (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,     // only when empty or being taken
  input  wire mlfd_pkg::mlfd_result_t result,
  input  wire logic                   ready,
  output logic                        valid,
  output mlfd_pkg::mlfd_result_t      held
);
  import mlfd_pkg::*;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= result.valid;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load && result.valid) held <= result;
  end

endmodule

`default_nettype wire

[sv/magic_length_frame_deframer_unit.sv]
// Data path: an accepted byte is held in the input register, then its result
//   word, if any, is loaded into the output register and shown on m_axis_tvalid.
// Throughput: one byte per cycle while the output register is free or taken;
//   input and output registers let a new byte in while a finished word waits.
// Reset: synchronous rst returns to sync search, clears counters and lengths,
//   and loads the configuration defaults.
// ----------------------------------------------------------------------------
// magic_length_frame_deframer_unit
// Byte-stream deframer: finds magic-prefixed frames with path/data length fields,
// passes path and data bytes out with a last-of-frame mark, reports bad headers.
// ----------------------------------------------------------------------------
`default_nettype none

module magic_length_frame_deframer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input byte stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // [7:0] payload, [23:8] path_length,
                                           // [55:24] data_length
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast,   // frame_last
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import mlfd_pkg::*;

  mlfd_cfg_t    cfg;
  logic         in_valid;
  logic [7:0]   in_byte;
  logic         advance;
  logic         step;
  mlfd_result_t result;
  mlfd_result_t out_word;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_magic  <= FIRST_MAGIC_RST;
      cfg.second_magic <= SECOND_MAGIC_RST;
      cfg.path_limit   <= PATH_LIMIT_RST;
      cfg.data_limit   <= DATA_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIRST_MAGIC:  cfg.first_magic  <= cfg_data[7:0];
        CFG_SECOND_MAGIC: cfg.second_magic <= cfg_data[7:0];
        CFG_PATH_LIMIT:   cfg.path_limit   <= cfg_data[16:0];
        CFG_DATA_LIMIT:   cfg.data_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register; pipeline moves when the output register is free or being taken
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) in_byte <= s_axis_tdata;
  end

  mlfd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_byte),
    .cfg     (cfg),
    .result  (result)
  );

  mlfd_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (step),
    .result (result),
    .ready  (m_axis_tready),
    .valid  (m_axis_tvalid),
    .held   (out_word)
  );

  // Output packing
  assign m_axis_tdata = {out_word.data_length, out_word.path_length, out_word.payload};
  assign m_axis_tuser = out_word.kind;
  assign m_axis_tlast = out_word.last;

  // Checks
  a_reject_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_REJECT) |-> !m_axis_tlast)
    else $error("rejection word marked as frame end");

  a_reject_zero_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_REJECT) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("rejection word carries a payload byte");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == KIND_PATH || m_axis_tuser == KIND_DATA ||
                       m_axis_tuser == KIND_REJECT))
    else $error("result word with unused kind");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while both stages are full");

endmodule

`default_nettype wire
